// ===== sv/atrlc_pkg.sv =====
// Package for the AT response line classifier: prefix tables, codes and shared types.
`timescale 1ns / 1ps

package atrlc_pkg;

    localparam int NUM_PFX  = 30;
    localparam int PFX_MAXL = 19;
    localparam int CLS_W    = 5;
    localparam int LEN_W    = 9;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [LEN_W-1:0] LEN_SAT = 9'd511;

    localparam logic [CLS_W-1:0] CLS_UNKNOWN = 5'd0;

    typedef enum logic
    {
        STAT_LINE     = 1'b0,
        STAT_OVERFLOW = 1'b1
    } status_t;

    typedef logic [8*PFX_MAXL-1:0] pfx_str_t;

    // Strings are right-justified: the last character sits in the low byte.
    localparam pfx_str_t PFX_TEXT [NUM_PFX] = '{
        "^BOOT:", "+CNUM:", "ERROR+CNUM:", "OK", "^RSSI:", "^MODE:",
        "^CEND:", "+CSSI:", "^ORIG:", "^CONF:", "^CONN:", "+CREG:",
        "+COPS:", "^SRVST:", "+CSQ:", "+CPIN:", "RING", "+CLIP:",
        "ERROR", "+CMTI:", "+CMGR:", "+CSSU:", "BUSY", "NO DIALTONE",
        "NO CARRIER", "COMMAND NOT SUPPORT", "+CMS ERROR:", "^SMMEMFULL:",
        "> ", "+CUSD:"
    };

    localparam logic [4:0] PFX_LEN [NUM_PFX] = '{
        5'd6, 5'd6, 5'd11, 5'd2, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
        5'd6, 5'd6, 5'd6, 5'd7, 5'd5, 5'd6, 5'd4, 5'd6, 5'd5, 5'd6,
        5'd6, 5'd6, 5'd4, 5'd11, 5'd10, 5'd19, 5'd11, 5'd11, 5'd2, 5'd6
    };

    localparam logic [CLS_W-1:0] PFX_CLASS [NUM_PFX] = '{
        5'd1, 5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
        5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd18, 5'd25, 5'd26, 5'd27, 5'd28
    };

    typedef struct packed
    {
        logic [NUM_PFX-1:0] alive_next;
        logic [CLS_W-1:0]   cls;
    } match_t;

endpackage

// ===== sv/atrlc_match.sv =====
// Prefix matcher: per-byte still-matching update and first-match class lookup.
`timescale 1ns / 1ps

module atrlc_match #(
    parameter int CNT_W = 9
) (
    input  logic [atrlc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [CNT_W-1:0]              line_count,
    input  logic [atrlc_pkg::NUM_PFX-1:0] alive,
    output atrlc_pkg::match_t             result
);
    import atrlc_pkg::*;

    logic [4:0] pos5;

    assign pos5 = line_count[4:0];

    always_comb
    begin
        logic [4:0] k;
        logic       found;
        result.alive_next = alive;
        result.cls        = CLS_UNKNOWN;
        found             = 1'b0;
        k                 = '0;
        for (int i = 0; i < NUM_PFX; i++)
        begin
            // only positions inside the prefix take part in the compare
            if (line_count < CNT_W'(PFX_LEN[i]))
            begin
                k = PFX_LEN[i] - 5'd1 - pos5;
                if (PFX_TEXT[i][k*8 +: 8] != rx_byte)
                begin
                    result.alive_next[i] = 1'b0;
                end
            end
            if (!found && alive[i] && (line_count >= CNT_W'(PFX_LEN[i])))
            begin
                found      = 1'b1;
                result.cls = PFX_CLASS[i];
            end
        end
    end

endmodule

// ===== sv/at_response_line_classifier.sv =====
// Top level of the AT response line classifier.
`timescale 1ns / 1ps
//
// Bytes from the modem enter on the s_ stream, one per transaction. CR and LF
// outside a line are dropped silently; any other byte opens a line. A CR or LF
// inside a line closes it and emits one result on the m_ stream: tuser = 0,
// class code and line length in tdata. A byte arriving when the line already
// holds LINE_MAX bytes is dropped and emits an overflow result (tuser = 1,
// class 0, current length); the line stays open.
// Throughput: one byte per cycle while s_tready is high. Latency: a result is
// valid on m_ the cycle after the closing or overflowing byte is accepted; it is
// set by the single result register behind the prefix matcher.
// When the receiver stalls, the result register holds and s_tready drops
// only while a held result is still waiting; the byte that frees the register
// in the same cycle is taken. Reset clears the line state (no open line,
// length 0, all prefixes alive) and empties the result register.
// Line lengths above 511 are reported as 511.

module at_response_line_classifier #(
    parameter int LINE_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [4:0] response_class, [13:5] line_length, zero fill
    output logic        m_tuser     // [0] status
);
    import atrlc_pkg::*;

    localparam int CNT_W = $clog2(LINE_MAX + 1);
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic               in_line_reg, in_line_next;
    logic [CNT_W-1:0]   line_count_reg, line_count_next;
    logic [NUM_PFX-1:0] alive_reg, alive_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    status_t            status_reg, status_next;

    logic               accept;
    logic               eol;
    logic               emit;
    logic [EXT_W-1:0]   cnt_ext;
    logic [LEN_W-1:0]   len_sat;
    match_t             match;

    atrlc_match #(
        .CNT_W (CNT_W)
    ) u_match (
        .rx_byte    (s_tdata),
        .line_count (line_count_reg),
        .alive      (alive_reg),
        .result     (match)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign eol      = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);

    assign cnt_ext = EXT_W'(line_count_reg);
    assign len_sat = (cnt_ext > EXT_W'(LEN_SAT)) ? LEN_SAT : cnt_ext[LEN_W-1:0];

    always_comb
    begin
        in_line_next    = in_line_reg;
        line_count_next = line_count_reg;
        alive_next      = alive_reg;
        emit            = 1'b0;
        cls_next        = cls_reg;
        len_next        = len_reg;
        status_next     = status_reg;
        if (accept)
        begin
            if (!in_line_reg)
            begin
                if (!eol)
                begin
                    in_line_next    = 1'b1;
                    line_count_next = line_count_reg + CNT_W'(1);
                    alive_next      = match.alive_next;
                end
            end
            else if (eol)
            begin
                emit            = 1'b1;
                status_next     = STAT_LINE;
                cls_next        = match.cls;
                len_next        = len_sat;
                in_line_next    = 1'b0;
                line_count_next = '0;
                alive_next      = '1;
            end
            else if (line_count_reg >= CNT_W'(LINE_MAX))
            begin
                emit        = 1'b1;
                status_next = STAT_OVERFLOW;
                cls_next    = CLS_UNKNOWN;
                len_next    = len_sat;
            end
            else
            begin
                line_count_next = line_count_reg + CNT_W'(1);
                alive_next      = match.alive_next;
            end
        end
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg    <= 1'b0;
            line_count_reg <= '0;
            alive_reg      <= '1;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            in_line_reg    <= in_line_next;
            line_count_reg <= line_count_next;
            alive_reg      <= alive_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // result payload, loaded only when a transaction produces a result
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cls_reg    <= cls_next;
            len_reg    <= len_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, len_reg, cls_reg};
    assign m_tuser  = status_reg;

    // the kept-byte count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= CNT_W'(LINE_MAX))
        else $error("line count above capacity");

    // between lines the count and match vector are back at their idle values
    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        !in_line_reg |-> (line_count_reg == '0) && (alive_reg == '1))
        else $error("idle state not cleared");

    // an open line always holds at least one byte
    a_open_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        in_line_reg |-> (line_count_reg != '0))
        else $error("open line with zero length");

    // a line end inside a line yields a result in the next cycle
    a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_line_reg && eol |=> m_tvalid_reg && (status_reg == STAT_LINE))
        else $error("line end without result");

    // a known class needs a line at least as long as the shortest prefix
    a_class_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (cls_reg != CLS_UNKNOWN) |-> (len_reg >= LEN_W'(2)))
        else $error("class reported for too short a line");

endmodule

// ===== sim/at_response_line_classifier_test.sv =====
// Self-checking testbench for the AT response line classifier stream block.
`timescale 1ns / 1ps

module at_response_line_classifier_test;

    import atrlc_pkg::*;

    localparam int LINE_CAP    = 256;
    localparam int LIVE_TARGET = 1700;
    localparam int QUIET_AFTER = 1550;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN       = 8;

    typedef struct packed
    {
        status_t            st;
        logic [CLS_W-1:0]   cls;
        logic [LEN_W-1:0]   len;
    } line_result_t;

    typedef struct
    {
        logic [7:0]   rx;
        int           reps;
        bit           typed;
        line_result_t want;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [4:0] response_class, [13:5] line_length, zero fill
    logic        m_tuser;             // [0] status

    // line tracker mirroring the block
    logic               line_open = 1'b0;
    int unsigned        line_len  = 0;
    logic [NUM_PFX-1:0] pfx_live  = '1;

    line_result_t exp_lines[$];
    stim_row_t    plan[$];
    int           errors      = 0;
    int           live_items  = 0;
    int           lines_seen  = 0;
    int           idle_cycles = 0;
    bit           quiet       = 1'b0;
    bit           hold_done   = 1'b0;

    at_response_line_classifier #(
        .LINE_MAX (LINE_CAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // prefix strings are right-justified in the package table
    function automatic logic [7:0] pfx_char(input int i, input int pos);
        return PFX_TEXT[i][8*(int'(PFX_LEN[i]) - 1 - pos) +: 8];
    endfunction

    function automatic bit is_eol(input logic [7:0] b);
        return (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

    function automatic logic [LEN_W-1:0] reported_len();
        return (line_len > LEN_SAT) ? LEN_SAT : LEN_W'(line_len);
    endfunction

    function automatic void keep_line_byte(input logic [7:0] b);
        for (int i = 0; i < NUM_PFX; i++)
        begin
            if (line_len < PFX_LEN[i] && pfx_char(i, line_len) != b)
                pfx_live[i] = 1'b0;
        end
        line_len++;
    endfunction

    function automatic logic [CLS_W-1:0] line_class();
        for (int i = 0; i < NUM_PFX; i++)
        begin
            if (pfx_live[i] && line_len >= PFX_LEN[i])
                return PFX_CLASS[i];
        end
        return CLS_UNKNOWN;
    endfunction

    // advances the line tracker by one byte; returns 1 when a result is due
    function automatic bit track_byte(input logic [7:0] b, output line_result_t r);
        r = '0;
        if (!line_open)
        begin
            if (!is_eol(b))
            begin
                line_open = 1'b1;
                keep_line_byte(b);
            end
            return 1'b0;
        end
        if (is_eol(b))
        begin
            r.st      = STAT_LINE;
            r.cls     = line_class();
            r.len     = reported_len();
            line_open = 1'b0;
            line_len  = 0;
            pfx_live  = '1;
            return 1'b1;
        end
        if (line_len >= LINE_CAP)
        begin
            r.st  = STAT_OVERFLOW;
            r.cls = CLS_UNKNOWN;
            r.len = reported_len();
            return 1'b1;
        end
        keep_line_byte(b);
        return 1'b0;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
        while (is_eol(b));
        return b;
    endfunction

    function automatic logic [7:0] eol_byte();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    function automatic void add_row(input logic [7:0] rx, input int reps = 1,
                                    input bit typed = 1'b0, input status_t st = STAT_LINE,
                                    input logic [CLS_W-1:0] cls = CLS_UNKNOWN,
                                    input logic [LEN_W-1:0] len = '0);
        stim_row_t row;
        row.rx        = rx;
        row.reps      = reps;
        row.typed     = typed;
        row.want.st   = st;
        row.want.cls  = cls;
        row.want.len  = len;
        plan.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // one byte transaction; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input line_result_t want = '0);
        line_result_t r;
        bit           due;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        if (line_open || !is_eol(b))
            live_items++;
        due = track_byte(b, r);
        if (due)
            exp_lines.push_back(typed ? want : r);
        if (live_items >= QUIET_AFTER)
            quiet = 1'b1;
        @(negedge clk);
    endtask

    task automatic send_random_line();
        int         kind;
        int         pi;
        int         cut;
        logic [7:0] ch;
        kind = $urandom_range(0, 99);
        repeat ($urandom_range(0, 2)) send_byte(eol_byte());
        if (kind < 72)
        begin
            // known prefix, sometimes cut short or with bytes corrupted
            pi  = $urandom_range(0, NUM_PFX - 1);
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, PFX_LEN[pi]) : PFX_LEN[pi];
            for (int k = 0; k < cut; k++)
            begin
                ch = pfx_char(pi, k);
                if ($urandom_range(0, 19) == 0)
                    ch = text_byte();
                send_byte(ch);
            end
            repeat ($urandom_range(0, 12)) send_byte(text_byte());
        end
        else if (kind < 88)
        begin
            repeat ($urandom_range(1, 20)) send_byte(text_byte());
        end
        else if (kind < 98)
        begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            // long line around the capacity limit
            repeat ($urandom_range(LINE_CAP - 6, LINE_CAP + 6)) send_byte(text_byte());
        end
        send_byte(eol_byte());
    endtask

    initial
    begin : reset_gen
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : stimulus
        @(posedge rst_n);
        @(negedge clk);

        add_row(CHAR_CR);                       // ignored, no line open
        add_row(CHAR_LF);
        add_row("O");
        add_row("K");
        add_row(CHAR_CR, 1, 1'b1, STAT_LINE, 5'd3, 9'd2);
        add_row(CHAR_LF);
        add_row("O");                           // shorter than the OK prefix
        add_row(CHAR_LF, 1, 1'b1, STAT_LINE, CLS_UNKNOWN, 9'd1);
        add_row(8'h00);
        add_row(8'hFF);
        add_row(CHAR_LF, 1, 1'b1, STAT_LINE, CLS_UNKNOWN, 9'd2);
        add_row(">");
        add_row(" ");
        add_row(CHAR_CR, 1, 1'b1, STAT_LINE, 5'd27, 9'd2);
        add_row("B");
        add_row("U");
        add_row("S");
        add_row("Y");
        add_row("!");
        add_row(CHAR_LF);
        add_row("A", LINE_CAP);                 // fill to capacity
        add_row(8'hFF, 1, 1'b1, STAT_OVERFLOW, CLS_UNKNOWN, 9'd256);
        add_row(8'h00, 1, 1'b1, STAT_OVERFLOW, CLS_UNKNOWN, 9'd256);
        add_row(CHAR_CR, 1, 1'b1, STAT_LINE, CLS_UNKNOWN, 9'd256);

        foreach (plan[i])
        begin
            for (int k = 0; k < plan[i].reps; k++)
                send_byte(plan[i].rx, plan[i].typed && (k == plan[i].reps - 1), plan[i].want);
        end

        while (live_items < LIVE_TARGET)
            send_random_line();
        s_tvalid <= 1'b0;

        while (exp_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : sink
        int gap;
        gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            // one long hold-off so the result register fills and the input stalls
            if (!hold_done && lines_seen >= 15)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (!quiet && gap == 0 && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 10);
            end
            if (gap > 0 && !quiet)
            begin
                m_tready <= 1'b0;
                gap--;
            end
            else
            begin
                m_tready <= 1'b1;
                gap = 0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        line_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_lines.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result tuser=%0d tdata=%h",
                                          m_tuser, m_tdata));
            end
            else
            begin
                want = exp_lines.pop_front();
                if (m_tuser !== want.st)
                    report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.st));
                if (m_tdata[4:0] !== want.cls)
                    report_mismatch($sformatf("class %0d, want %0d", m_tdata[4:0], want.cls));
                if (m_tdata[13:5] !== want.len)
                    report_mismatch($sformatf("length %0d, want %0d", m_tdata[13:5], want.len));
            end
            lines_seen++;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
sv/atrlc_pkg.sv
sv/atrlc_match.sv
sv/at_response_line_classifier.sv
sim/at_response_line_classifier_test.sv
